// ===== hw/rtl/radial_frequency_gain_core_macros.svh =====
// radial_frequency_gain_core_macros.svh: assertion macros for the gain core.
// No dependencies; included by radial_frequency_gain_core for its checks.
`ifndef RADIAL_FREQUENCY_GAIN_CORE_MACROS_SVH
`define RADIAL_FREQUENCY_GAIN_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RFG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rfg assertion failed");
`define RFG_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rfg forbidden condition seen");
`else
`define RFG_ASSERT(lbl, clk, rst_n, prop)
`define RFG_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/rfg_pkg.sv =====
// rfg_pkg: widths, constants, exp table and register codes of the gain core.
// No dependencies; used by the interfaces, rfg_exp and the core.
`timescale 1ns / 1ps
package rfg_pkg;
    localparam int COEF_BITS_DEF = 32;
    localparam int MAX_DIM       = 4096;
    localparam int FREQ_W        = 12;
    localparam int DIM_W         = 13;
    localparam int LAMBDA_W      = 16;
    localparam int Q_FRAC        = 16;
    localparam int XY_W          = 30;
    localparam int SQ_W          = 62;
    localparam int RHO_W         = 31;
    localparam int EXP_W         = 31;
    localparam int EXP_STAGES    = 21;
    localparam int G_W           = 48;
    localparam int GMAG_W        = 32;
    localparam int GAIN_SHIFT    = 14;
    localparam int AREA_W        = 25;
    localparam int DEN_SHIFT     = 24;
    localparam int APB_AW        = 4;
    localparam int APB_DW        = 32;

    localparam logic [EXP_W-1:0] ONE_Q30 = EXP_W'(1) << (EXP_W - 1);
    localparam logic signed [G_W-1:0] G_BIAS = G_W'(1) << 38;
    localparam logic [G_W-1:0] G_ROUND = G_W'(1) << (GAIN_SHIFT - 1);

    localparam logic [DIM_W-1:0]    DIM_RESET    = DIM_W'(256);
    localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = LAMBDA_W'(256);

    // exp(-2^(k-16)) in Q30 for each bit k of rho
    localparam logic [29:0] EXP_TAB [EXP_STAGES] = '{
        30'd1073725440, 30'd1073709056, 30'd1073676290, 30'd1073610760,
        30'd1073479712, 30'd1073217664, 30'd1072693760, 30'd1071646719,
        30'd1069555701, 30'd1065385899, 30'd1057095000, 30'd1040706261,
        30'd1008687096, 30'd947573834,  30'd836230973,  30'd651257337,
        30'd395007542,  30'd145315154,  30'd19666267,   30'd360201,
        30'd121
    };

    typedef enum logic [1:0] {
        REG_LAMBDA = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } t_reg_idx;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction
endpackage

// ===== hw/rtl/rfg_in_if.sv =====
// rfg_in_if: input channel of the gain core, one DFT coefficient per transfer.
// Depends on rfg_pkg for field widths.
`timescale 1ns / 1ps
interface rfg_in_if #(
    parameter int COEF_BITS = rfg_pkg::COEF_BITS_DEF
) ();
    logic                                valid;
    logic                                ready;
    logic        [rfg_pkg::FREQ_W-1:0]   freq_x;
    logic signed [rfg_pkg::FREQ_W-1:0]   freq_y;
    logic signed [COEF_BITS-1:0]         coef_re;
    logic signed [COEF_BITS-1:0]         coef_im;

    modport source (output valid, freq_x, freq_y, coef_re, coef_im, input ready);
    modport sink   (input valid, freq_x, freq_y, coef_re, coef_im, output ready);
endinterface

// ===== hw/rtl/rfg_out_if.sv =====
// rfg_out_if: result channel of the gain core, one scaled coefficient per transfer.
// No package dependency beyond the default width.
`timescale 1ns / 1ps
interface rfg_out_if #(
    parameter int COEF_BITS = rfg_pkg::COEF_BITS_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic signed [COEF_BITS-1:0] out_re;
    logic signed [COEF_BITS-1:0] out_im;
    logic                        saturated;

    modport source (output valid, out_re, out_im, saturated, input ready);
    modport sink   (input valid, out_re, out_im, saturated, output ready);
endinterface

// ===== hw/rtl/rfg_div_pipe.sv =====
// rfg_div_pipe: multi-lane pipelined restoring divider, one quotient bit per stage.
// Standalone; the divisor must stay steady while items are in flight.
`timescale 1ns / 1ps
module rfg_div_pipe #(
    parameter int LANES = 2,
    parameter int DW    = 30,
    parameter int VW    = 13,
    parameter int TW    = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [LANES-1:0][DW-1:0]   i_num,
    input  logic [LANES-1:0][VW-1:0]   i_den,
    input  logic [TW-1:0]              i_tag,
    output logic                       o_valid,
    output logic [LANES-1:0][DW-1:0]   o_quo,
    output logic [TW-1:0]              o_tag
);
    logic          r_valid [DW];
    logic [TW-1:0] r_tag   [DW];
    logic [VW-1:0] r_rem   [LANES][DW-1];
    logic [DW-1:0] r_num   [LANES][DW];

    for (genvar s = 0; s < DW; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= (s == 0) ? i_valid : r_valid[s == 0 ? 0 : s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[s] <= (s == 0) ? i_tag : r_tag[s == 0 ? 0 : s-1];
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [VW-1:0] p_rem;
            logic [DW-1:0] p_num;
            logic [VW:0]   t;
            logic          ge;

            if (s == 0) begin : g_first
                assign p_rem = '0;
                assign p_num = i_num[l];
            end else begin : g_next
                assign p_rem = r_rem[l][s-1];
                assign p_num = r_num[l][s-1];
            end

            // shift in the next dividend bit, subtract when it fits
            assign t  = {p_rem, p_num[DW-1]};
            assign ge = t >= {1'b0, i_den[l]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[l][s] <= {p_num[DW-2:0], ge};
                end
            end

            if (s < DW-1) begin : g_rem
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[l][s] <= ge ? VW'(t - {1'b0, i_den[l]}) : t[VW-1:0];
                    end
                end
            end
        end
    end

    assign o_valid = r_valid[DW-1];
    assign o_tag   = r_tag[DW-1];
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_quo[l] = r_num[l][DW-1];
    end
endmodule

// ===== hw/rtl/rfg_isqrt.sv =====
// rfg_isqrt: pipelined integer square root, one result bit per stage.
// Standalone; floor(sqrt) of an SW-bit unsigned value.
`timescale 1ns / 1ps
module rfg_isqrt #(
    parameter int SW = 62,
    parameter int TW = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SW-1:0]     i_sq,
    input  logic [TW-1:0]     i_tag,
    output logic              o_valid,
    output logic [SW/2-1:0]   o_root,
    output logic [TW-1:0]     o_tag
);
    localparam int NS = SW / 2;

    logic          r_valid [NS];
    logic [TW-1:0] r_tag   [NS];
    logic [SW-1:0] r_v     [NS-1];
    logic [SW-1:0] r_r     [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2*k);
        logic [SW-1:0] p_v;
        logic [SW-1:0] p_r;
        logic [SW-1:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign p_v = i_sq;
            assign p_r = '0;
        end else begin : g_next
            assign p_v = r_v[k-1];
            assign p_r = r_r[k-1];
        end

        assign trial = p_r + BIT;
        assign ge    = p_v >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= (k == 0) ? i_valid : r_valid[k == 0 ? 0 : k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[k] <= (k == 0) ? i_tag : r_tag[k == 0 ? 0 : k-1];
                r_r[k]   <= ge ? (p_r >> 1) + BIT : p_r >> 1;
            end
        end

        if (k < NS-1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v[k] <= ge ? p_v - trial : p_v;
                end
            end
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_tag   = r_tag[NS-1];
    assign o_root  = r_r[NS-1][NS-1:0];
endmodule

// ===== hw/rtl/rfg_exp.sv =====
// rfg_exp: pipelined exp(-rho) in Q30, one table multiply per rho bit 0 to 20.
// Depends on rfg_pkg for the table and widths.
`timescale 1ns / 1ps
module rfg_exp #(
    parameter int TW = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [rfg_pkg::RHO_W-1:0]   i_rho,
    input  logic [TW-1:0]               i_tag,
    output logic                        o_valid,
    output logic [rfg_pkg::EXP_W-1:0]   o_exp,
    output logic [TW-1:0]               o_tag
);
    localparam int NS = rfg_pkg::EXP_STAGES;
    localparam int AW = rfg_pkg::EXP_W;
    localparam int RW = rfg_pkg::RHO_W;
    localparam int PW = AW + 30;

    logic          r_valid [NS];
    logic [TW-1:0] r_tag   [NS];
    logic          r_zero  [NS];
    logic [AW-1:0] r_acc   [NS];
    logic [RW-1:0] r_rho   [NS-1];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [AW-1:0] p_acc;
        logic [RW-1:0] p_rho;
        logic          p_zero;
        logic [PW-1:0] prod;

        if (k == 0) begin : g_first
            assign p_acc  = rfg_pkg::ONE_Q30;
            assign p_rho  = i_rho;
            // rho of 32.0 or more underflows to zero
            assign p_zero = |i_rho[RW-1:NS];
        end else begin : g_next
            assign p_acc  = r_acc[k-1];
            assign p_rho  = r_rho[k-1];
            assign p_zero = r_zero[k-1];
        end

        assign prod = p_acc * rfg_pkg::EXP_TAB[k] + (PW'(1) << 29);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= (k == 0) ? i_valid : r_valid[k == 0 ? 0 : k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[k]  <= (k == 0) ? i_tag : r_tag[k == 0 ? 0 : k-1];
                r_zero[k] <= p_zero;
                r_acc[k]  <= p_rho[k] ? prod[PW-1:30] : p_acc;
            end
        end

        if (k < NS-1) begin : g_rho
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rho[k] <= p_rho;
                end
            end
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_tag   = r_tag[NS-1];
    assign o_exp   = r_zero[NS-1] ? '0 : r_acc[NS-1];
endmodule

// ===== hw/rtl/radial_frequency_gain_core.sv =====
// radial_frequency_gain_core: one item per cycle while the skid slot is empty.
// The depth is set by the two bit-serial dividers, the sqrt and exp pipelines.
// Reset (synchronous, active low) empties the pipeline and the output buffer
// and loads lambda 1.0 and a 256 x 256 image. No clearing pass is needed.
// Depends on rfg_pkg, rfg_in_if, rfg_out_if, rfg_div_pipe, rfg_isqrt, rfg_exp.
`timescale 1ns / 1ps
module radial_frequency_gain_core #(
    parameter int COEF_BITS = rfg_pkg::COEF_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rfg_in_if.sink                       i_in,
    rfg_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rfg_pkg::APB_AW-1:0]   paddr,
    input  logic [rfg_pkg::APB_DW-1:0]   pwdata,
    output logic [rfg_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    localparam int CB     = COEF_BITS;
    localparam int PW     = CB + rfg_pkg::GMAG_W + 1;   // product plus rounding
    localparam int QW     = PW - rfg_pkg::DEN_SHIFT;    // quotient width
    localparam int XY_W   = rfg_pkg::XY_W;
    localparam int DIM_W  = rfg_pkg::DIM_W;
    localparam int G_W    = rfg_pkg::G_W;
    localparam int GMAG_W = rfg_pkg::GMAG_W;
    localparam logic [CB-1:0] MAX_V = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] MIN_V = {1'b1, {(CB-1){1'b0}}};

    // ---------------------------------------------------------------
    // Configuration registers. Writes land on the access phase.
    // ---------------------------------------------------------------
    logic [rfg_pkg::LAMBDA_W-1:0] r_lambda;
    logic [DIM_W-1:0]             r_width;
    logic [DIM_W-1:0]             r_height;
    logic                         cfg_wr;
    rfg_pkg::t_reg_idx            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = rfg_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda <= rfg_pkg::LAMBDA_RESET;
            r_width  <= rfg_pkg::DIM_RESET;
            r_height <= rfg_pkg::DIM_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                rfg_pkg::REG_LAMBDA: r_lambda <= pwdata[rfg_pkg::LAMBDA_W-1:0];
                rfg_pkg::REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                rfg_pkg::REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                default: ;  // index beyond the list: drop the write
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            rfg_pkg::REG_LAMBDA: prdata = rfg_pkg::APB_DW'(r_lambda);
            rfg_pkg::REG_WIDTH:  prdata = rfg_pkg::APB_DW'(r_width);
            rfg_pkg::REG_HEIGHT: prdata = rfg_pkg::APB_DW'(r_height);
            default:             prdata = '0;
        endcase
    end

    // Clamped dimensions and the image area for the final divide. The area
    // register follows in the cycle after a write, before any later item needs it.
    logic [DIM_W-1:0]             dim_w;
    logic [DIM_W-1:0]             dim_h;
    logic [rfg_pkg::AREA_W-1:0]   r_area;

    assign dim_w = rfg_pkg::clamp_dim(r_width);
    assign dim_h = rfg_pkg::clamp_dim(r_height);

    always_ff @(posedge i_clk) begin
        r_area <= rfg_pkg::AREA_W'(dim_w * dim_h);
    end

    // ---------------------------------------------------------------
    // Global advance. The whole pipeline moves unless the skid slot
    // holds a result; the output register and skid slot decouple the
    // result side so each stalled sink cycle costs at most one input bubble.
    // ---------------------------------------------------------------
    logic en;
    logic r_skid_valid;

    assign en         = !r_skid_valid;
    assign i_in.ready = en;

    // ---------------------------------------------------------------
    // Normalized frequencies: x = round(2a*2^16/W), y = round(2|b|*2^16/H).
    // ---------------------------------------------------------------
    logic [rfg_pkg::FREQ_W-1:0]      y_mag;
    logic [1:0][XY_W-1:0]            xy_num;
    logic [1:0][DIM_W-1:0]           xy_den;
    logic                            xy_valid;
    logic [1:0][XY_W-1:0]            xy_quo;
    logic [2*CB-1:0]                 xy_tag;

    assign y_mag     = i_in.freq_y[rfg_pkg::FREQ_W-1] ? rfg_pkg::FREQ_W'(-i_in.freq_y)
                                                      : i_in.freq_y;
    assign xy_num[0] = (XY_W'(i_in.freq_x) << (rfg_pkg::Q_FRAC + 1)) + XY_W'(dim_w >> 1);
    assign xy_num[1] = (XY_W'(y_mag) << (rfg_pkg::Q_FRAC + 1)) + XY_W'(dim_h >> 1);
    assign xy_den[0] = dim_w;
    assign xy_den[1] = dim_h;

    rfg_div_pipe #(
        .LANES (2),
        .DW    (XY_W),
        .VW    (DIM_W),
        .TW    (2*CB)
    ) u_div_xy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_num   (xy_num),
        .i_den   (xy_den),
        .i_tag   ({i_in.coef_im, i_in.coef_re}),
        .o_valid (xy_valid),
        .o_quo   (xy_quo),
        .o_tag   (xy_tag)
    );

    // ---------------------------------------------------------------
    // Squares, then their sum.
    // ---------------------------------------------------------------
    logic                       r_s1_valid;
    logic [2*XY_W-1:0]          r_xx;
    logic [2*XY_W-1:0]          r_yy;
    logic [2*CB-1:0]            r_s1_tag;
    logic                       r_s2_valid;
    logic [rfg_pkg::SQ_W-1:0]   r_sq;
    logic [2*CB-1:0]            r_s2_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= xy_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xx     <= xy_quo[0] * xy_quo[0];
            r_yy     <= xy_quo[1] * xy_quo[1];
            r_s1_tag <= xy_tag;
            r_sq     <= rfg_pkg::SQ_W'(r_xx) + rfg_pkg::SQ_W'(r_yy);
            r_s2_tag <= r_s1_tag;
        end
    end

    // ---------------------------------------------------------------
    // rho = floor(sqrt(x^2 + y^2)) in Q16, then exp(-rho) in Q30.
    // ---------------------------------------------------------------
    logic                        rho_valid;
    logic [rfg_pkg::RHO_W-1:0]   rho;
    logic [2*CB-1:0]             rho_tag;
    logic                        ex_valid;
    logic [rfg_pkg::EXP_W-1:0]   ex_val;
    logic [2*CB-1:0]             ex_tag;

    rfg_isqrt #(
        .SW (rfg_pkg::SQ_W),
        .TW (2*CB)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_valid),
        .i_sq    (r_sq),
        .i_tag   (r_s2_tag),
        .o_valid (rho_valid),
        .o_root  (rho),
        .o_tag   (rho_tag)
    );

    rfg_exp #(
        .TW (2*CB)
    ) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rho_valid),
        .i_rho   (rho),
        .i_tag   (rho_tag),
        .o_valid (ex_valid),
        .o_exp   (ex_val),
        .o_tag   (ex_tag)
    );

    // ---------------------------------------------------------------
    // Gain: g38 = 2^38 + lambda*(2^30 - e), kept as sign and Q24
    // magnitude rounded half away from zero.
    // ---------------------------------------------------------------
    logic signed [G_W-1:0]  n_g1_prod;
    logic                   r_g1_valid;
    logic signed [G_W-1:0]  r_g1_prod;
    logic [2*CB-1:0]        r_g1_tag;
    logic signed [G_W-1:0]  n_g38;
    logic [G_W-1:0]         n_gabs;
    logic [G_W-1:0]         n_grnd;
    logic                   r_g2_valid;
    logic                   r_gneg;
    logic [GMAG_W-1:0]      r_gmag;
    logic [2*CB-1:0]        r_g2_tag;

    assign n_g1_prod = $signed(r_lambda) * $signed({1'b0, rfg_pkg::ONE_Q30 - ex_val});
    assign n_g38     = r_g1_prod + rfg_pkg::G_BIAS;
    assign n_gabs    = n_g38[G_W-1] ? G_W'(-n_g38) : G_W'(n_g38);
    assign n_grnd    = n_gabs + rfg_pkg::G_ROUND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1_valid <= 1'b0;
            r_g2_valid <= 1'b0;
        end else if (en) begin
            r_g1_valid <= ex_valid;
            r_g2_valid <= r_g1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g1_prod <= n_g1_prod;
            r_g1_tag  <= ex_tag;
            r_gneg    <= n_g38[G_W-1];
            r_gmag    <= n_grnd[rfg_pkg::GAIN_SHIFT +: GMAG_W];
            r_g2_tag  <= r_g1_tag;
        end
    end

    // ---------------------------------------------------------------
    // Coefficient magnitude times gain, as two 16-bit partial products,
    // then the sum with half the denominator added for rounding.
    // ---------------------------------------------------------------
    logic [1:0][CB-1:0]       n_mag;
    logic [1:0]               n_neg;
    logic [1:0][CB+15:0]      n_pp_lo;
    logic [1:0][CB+15:0]      n_pp_hi;
    logic [1:0][PW-1:0]       n_sum;
    logic                     r_m1_valid;
    logic [1:0][CB+15:0]      r_pp_lo;
    logic [1:0][CB+15:0]      r_pp_hi;
    logic [1:0]               r_m1_neg;
    logic                     r_m2_valid;
    logic [1:0][QW-1:0]       r_m2_num;
    logic [1:0]               r_m2_neg;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_neg[l]   = r_g2_tag[l*CB + CB - 1] ^ r_gneg;
            n_mag[l]   = r_g2_tag[l*CB + CB - 1] ? CB'(-r_g2_tag[l*CB +: CB])
                                                 : r_g2_tag[l*CB +: CB];
            n_pp_lo[l] = n_mag[l] * r_gmag[15:0];
            n_pp_hi[l] = n_mag[l] * r_gmag[GMAG_W-1:16];
            n_sum[l]   = PW'(r_pp_lo[l]) + (PW'(r_pp_hi[l]) << 16)
                       + (PW'(r_area) << (rfg_pkg::DEN_SHIFT - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
            r_m2_valid <= 1'b0;
        end else if (en) begin
            r_m1_valid <= r_g2_valid;
            r_m2_valid <= r_m1_valid;
        end
    end

    // The denominator is area * 2^24, so drop the low 24 bits of the
    // dividend and divide by the area alone: the quotient is the same.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pp_lo  <= n_pp_lo;
            r_pp_hi  <= n_pp_hi;
            r_m1_neg <= n_neg;
            for (int l = 0; l < 2; l++) begin
                r_m2_num[l] <= n_sum[l][PW-1:rfg_pkg::DEN_SHIFT];
            end
            r_m2_neg <= r_m1_neg;
        end
    end

    logic                             q_valid;
    logic [1:0][QW-1:0]               q_quo;
    logic [1:0]                       q_neg;

    rfg_div_pipe #(
        .LANES (2),
        .DW    (QW),
        .VW    (rfg_pkg::AREA_W),
        .TW    (2)
    ) u_div_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_m2_valid),
        .i_num   (r_m2_num),
        .i_den   ({r_area, r_area}),
        .i_tag   (r_m2_neg),
        .o_valid (q_valid),
        .o_quo   (q_quo),
        .o_tag   (q_neg)
    );

    // ---------------------------------------------------------------
    // Saturate to the signed range and restore the sign.
    // ---------------------------------------------------------------
    logic [1:0][QW-1:0]  n_lim;
    logic [1:0]          n_sat;
    logic [1:0][QW-1:0]  n_qs;
    logic [1:0][QW-1:0]  n_qn;
    logic                r_f_valid;
    logic [1:0][CB-1:0]  r_f_val;
    logic                r_f_sat;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_lim[l] = (QW'(1) << (CB - 1)) - QW'(!q_neg[l]);
            n_sat[l] = q_quo[l] > n_lim[l];
            n_qs[l]  = n_sat[l] ? n_lim[l] : q_quo[l];
            n_qn[l]  = q_neg[l] ? ~n_qs[l] + QW'(1) : n_qs[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_val[0] <= n_qn[0][CB-1:0];
            r_f_val[1] <= n_qn[1][CB-1:0];
            r_f_sat    <= |n_sat;
        end
    end

    // ---------------------------------------------------------------
    // Output register with one skid slot. The skid slot fills only when
    // the sink stalls a valid result; it drains first when the sink takes.
    // ---------------------------------------------------------------
    logic                r_out_valid;
    logic [1:0][CB-1:0]  r_out_val;
    logic                r_out_sat;
    logic [1:0][CB-1:0]  r_skid_val;
    logic                r_skid_sat;
    logic                load_out;

    assign load_out = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (load_out) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (load_out) begin
            r_out_valid <= r_f_valid;
        end else if (r_f_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (load_out) begin
                r_out_val <= r_skid_val;
                r_out_sat <= r_skid_sat;
            end
        end else if (load_out) begin
            r_out_val <= r_f_val;
            r_out_sat <= r_f_sat;
        end else begin
            r_skid_val <= r_f_val;
            r_skid_sat <= r_f_sat;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_re    = r_out_val[0];
    assign o_out.out_im    = r_out_val[1];
    assign o_out.saturated = r_out_sat;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    logic out_at_limit;

    assign out_at_limit = (r_out_val[0] == MAX_V) || (r_out_val[0] == MIN_V)
                       || (r_out_val[1] == MAX_V) || (r_out_val[1] == MIN_V);

`include "radial_frequency_gain_core_macros.svh"

    `RFG_NEVER(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid && !r_out_valid)
    `RFG_ASSERT(a_last_stage_holds, i_clk, i_rst_n, r_f_valid && r_skid_valid |=> r_f_valid)
    `RFG_ASSERT(a_sat_at_limit, i_clk, i_rst_n, r_out_valid && r_out_sat |-> out_at_limit)
endmodule
